// ===== rtl/core/balanced_dual_fifo_shared_store_core_defines.svh =====
// Assertion macros for the shared store core.
`ifndef BALANCED_DUAL_FIFO_SHARED_STORE_CORE_DEFINES_SVH
`define BALANCED_DUAL_FIFO_SHARED_STORE_CORE_DEFINES_SVH

`ifndef SYNTH
`define BDFS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("shared store check failed");
`define BDFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shared store sequence check failed");
`else
`define BDFS_ASSERT_ALWAYS(label, expr)
`define BDFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/bdfs_pkg.sv =====
package bdfs_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int COUNT_W   = 5;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]     fill_t;

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ1  = 2'd1,
        ACT_DEQ2  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic report;
    } dp_cmd_t;

endpackage

// ===== rtl/core/bdfs_ctrl.sv =====
module bdfs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output bdfs_pkg::dp_cmd_t cmd
);
    import bdfs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    assign can_load  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.update = 1'b1;
            end
            ST_REPORT:
            begin
                cmd.report = can_load;
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/bdfs_dpath.sv =====
module bdfs_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  bdfs_pkg::dp_cmd_t  cmd,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               accepted,
    output logic signed [31:0] first_head,
    output logic               first_head_valid,
    output logic signed [31:0] second_head,
    output logic               second_head_valid,
    output logic [4:0]         first_count,
    output logic [4:0]         second_count
);
    import bdfs_pkg::*;

    action_t             action_reg;
    word_t               value_reg;
    word_t               store_reg [CAPACITY];
    word_t               store_next [CAPACITY];
    fill_t               first_fill_reg;
    fill_t               first_fill_next;
    fill_t               second_fill_reg;
    fill_t               second_fill_next;
    logic                ok_reg;
    logic                ok_next;
    logic [CNT_W:0]      total;
    fill_t               second_inc;
    logic                out_ok_reg;
    word_t               first_head_reg;
    word_t               second_head_reg;
    logic                first_valid_reg;
    logic                second_valid_reg;
    logic [COUNT_W-1:0]  first_count_reg;
    logic [COUNT_W-1:0]  second_count_reg;

    assign total      = {1'b0, first_fill_reg} + {1'b0, second_fill_reg};
    assign second_inc = second_fill_reg + fill_t'(1);

    always_comb
    begin
        store_next       = store_reg;
        first_fill_next  = first_fill_reg;
        second_fill_next = second_fill_reg;
        ok_next          = 1'b0;
        unique case (action_reg)
            ACT_ENQ:
            begin
                if (total < (CNT_W + 1)'(CAPACITY))
                begin
                    ok_next = 1'b1;
                    if (first_fill_reg < second_fill_reg)
                    begin
                        store_next[first_fill_reg[IDX_W-1:0]] = value_reg;
                        first_fill_next = first_fill_reg + fill_t'(1);
                    end
                    else
                    begin
                        store_next[IDX_W'(CAPACITY) - second_inc[IDX_W-1:0]] = value_reg;
                        second_fill_next = second_inc;
                    end
                end
            end
            ACT_DEQ1:
            begin
                if (first_fill_reg != '0)
                begin
                    ok_next = 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (fill_t'(i + 1) < first_fill_reg)
                        begin
                            store_next[i] = store_reg[i + 1];
                        end
                    end
                    first_fill_next = first_fill_reg - fill_t'(1);
                end
            end
            ACT_DEQ2:
            begin
                if (second_fill_reg != '0)
                begin
                    ok_next = 1'b1;
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if ((CNT_W + 1)'(i) + {1'b0, second_fill_reg}
                                > (CNT_W + 1)'(CAPACITY))
                        begin
                            store_next[i] = store_reg[i - 1];
                        end
                    end
                    second_fill_next = second_fill_reg - fill_t'(1);
                end
            end
            ACT_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_fill_reg  <= '0;
            second_fill_reg <= '0;
        end
        else if (cmd.update)
        begin
            first_fill_reg  <= first_fill_next;
            second_fill_reg <= second_fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(action);
            value_reg  <= word_t'(value);
        end
        if (cmd.update)
        begin
            store_reg <= store_next;
            ok_reg    <= ok_next;
        end
        if (cmd.report)
        begin
            out_ok_reg       <= ok_reg;
            first_valid_reg  <= first_fill_reg != '0;
            second_valid_reg <= second_fill_reg != '0;
            first_head_reg   <= (first_fill_reg != '0) ? store_reg[0] : '0;
            second_head_reg  <= (second_fill_reg != '0) ? store_reg[CAPACITY-1] : '0;
            first_count_reg  <= COUNT_W'(first_fill_reg);
            second_count_reg <= COUNT_W'(second_fill_reg);
        end
    end

    assign accepted          = out_ok_reg;
    assign first_head        = signed'(32'(first_head_reg));
    assign first_head_valid  = first_valid_reg;
    assign second_head       = signed'(32'(second_head_reg));
    assign second_head_valid = second_valid_reg;
    assign first_count       = first_count_reg;
    assign second_count      = second_count_reg;

endmodule

// ===== rtl/core/balanced_dual_fifo_shared_store_core.sv =====
// Each item passes through capture, store update and report. The report step waits
// while the result register is stalled, and no new item is taken until it has reported.
// Reset: both fill counts clear and no item is pending; store words are undefined until
// written. No clearing pass.
`include "balanced_dual_fifo_shared_store_core_defines.svh"

module balanced_dual_fifo_shared_store_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic signed [31:0] first_head,
    output logic               first_head_valid,
    output logic signed [31:0] second_head,
    output logic               second_head_valid,
    output logic [4:0]         first_count,
    output logic [4:0]         second_count
);
    import bdfs_pkg::*;

    dp_cmd_t cmd;

    bdfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    bdfs_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .action            (action),
        .value             (value),
        .accepted          (accepted),
        .first_head        (first_head),
        .first_head_valid  (first_head_valid),
        .second_head       (second_head),
        .second_head_valid (second_head_valid),
        .first_count       (first_count),
        .second_count      (second_count)
    );

    `BDFS_ASSERT_ALWAYS(a_fill_bound, !out_valid || ({1'b0, first_count} + {1'b0, second_count} <= 6'(CAPACITY)))
    `BDFS_ASSERT_ALWAYS(a_head_flags, !out_valid || ((first_head_valid == (first_count != '0)) && (second_head_valid == (second_count != '0))))
    `BDFS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    `BDFS_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.capture, cmd.update, cmd.report}))

endmodule

// ===== dv/balanced_dual_fifo_shared_store_core_tb.sv =====
`timescale 1ns / 1ps

module balanced_dual_fifo_shared_store_core_tb;

    import bdfs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic        accepted;
        logic [31:0] first_head;
        logic        first_head_valid;
        logic [31:0] second_head;
        logic        second_head_valid;
        logic [4:0]  first_count;
        logic [4:0]  second_count;
    } status_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               accepted;
    logic signed [31:0] first_head;
    logic               first_head_valid;
    logic signed [31:0] second_head;
    logic               second_head_valid;
    logic [4:0]         first_count;
    logic [4:0]         second_count;

    word_t   slots [CAPACITY];
    int      low_len;
    int      high_len;
    status_t expected_status [$];
    status_t got_status;
    status_t want_status;

    bit idle_en;
    int stall_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    balanced_dual_fifo_shared_store_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .value             (value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .accepted          (accepted),
        .first_head        (first_head),
        .first_head_valid  (first_head_valid),
        .second_head       (second_head),
        .second_head_valid (second_head_valid),
        .first_count       (first_count),
        .second_count      (second_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Queue pair model: first queue head at slot 0, second at the top slot.
    task automatic apply_queue_step(input action_t act, input word_t word);
        status_t s;
        logic    ok;
        begin
            ok = 1'b0;
            case (act)
                ACT_ENQ:
                begin
                    if (low_len + high_len < CAPACITY)
                    begin
                        if (low_len < high_len)
                        begin
                            slots[low_len] = word;
                            low_len++;
                        end
                        else
                        begin
                            high_len++;
                            slots[CAPACITY - high_len] = word;
                        end
                        ok = 1'b1;
                    end
                end
                ACT_DEQ1:
                begin
                    if (low_len > 0)
                    begin
                        for (int i = 0; i + 1 < low_len; i++)
                            slots[i] = slots[i + 1];
                        low_len--;
                        ok = 1'b1;
                    end
                end
                ACT_DEQ2:
                begin
                    if (high_len > 0)
                    begin
                        for (int i = CAPACITY - 1; i > CAPACITY - high_len; i--)
                            slots[i] = slots[i - 1];
                        high_len--;
                        ok = 1'b1;
                    end
                end
                default:
                    ok = 1'b1;
            endcase
            s.accepted          = ok;
            s.first_head_valid  = (low_len > 0);
            s.first_head        = (low_len > 0) ? 32'(slots[0]) : 32'd0;
            s.second_head_valid = (high_len > 0);
            s.second_head       = (high_len > 0) ? 32'(slots[CAPACITY - 1]) : 32'd0;
            s.first_count       = 5'(low_len);
            s.second_count      = 5'(high_len);
            expected_status.push_back(s);
        end
    endtask

    task automatic send_item(input action_t act, input word_t word);
        int gap;
        begin
            gap = 0;
            if (idle_en && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 6);
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            action   <= act;
            value    <= word;
            do
                @(posedge clk);
            while (in_stall);
            apply_queue_step(act, word);
        end
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic action_t pick_action(input int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            return ACT_ENQ;
        r = $urandom_range(0, 9);
        if (r < 9)
            return (r < 5) ? ACT_DEQ1 : ACT_DEQ2;
        return ACT_QUERY;
    endfunction

    // Empty store: query succeeds and both dequeues fail cleanly.
    task automatic test_empty_store();
        begin
            send_item(ACT_QUERY, 32'h1234_5678);
            send_item(ACT_DEQ1, 32'hFFFF_FFFF);
            send_item(ACT_DEQ2, 32'h0000_0000);
        end
    endtask

    // Fill both queues with extreme words, reject one more, then pop each side.
    task automatic test_fill_to_full();
        word_t fills [16];
        begin
            fills = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE,
                      32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                      32'h00FF_00FF, 32'hFF00_FF00, 32'h1357_9BDF, 32'hECA8_6420};
            for (int i = 0; i < CAPACITY; i++)
                send_item(ACT_ENQ, fills[i % 16]);
            send_item(ACT_ENQ, 32'hDEAD_BEEF);
            send_item(ACT_QUERY, 32'h0);
            send_item(ACT_DEQ1, 32'h0);
            send_item(ACT_DEQ2, 32'h0);
        end
    endtask

    // Phases of mostly-enqueue, balanced and mostly-dequeue traffic hit full and empty often.
    task automatic test_random_traffic(input int n_items);
        int enq_pct;
        int left;
        begin
            left = 0;
            enq_pct = 50;
            for (int i = 0; i < n_items; i++)
            begin
                if (left == 0)
                begin
                    left = $urandom_range(20, 60);
                    case ($urandom_range(0, 2))
                        0:       enq_pct = 85;
                        1:       enq_pct = 50;
                        default: enq_pct = 15;
                    endcase
                    idle_en = ($urandom_range(0, 3) != 0);
                end
                left--;
                send_item(pick_action(enq_pct), pick_word());
            end
        end
    endtask

    task automatic test_unthrottled_tail(input int n_items);
        begin
            idle_en = 1'b0;
            for (int i = 0; i < n_items; i++)
                send_item(pick_action((i / 40) % 2 == 0 ? 80 : 20), pick_word());
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (got !== want)
                flag_mismatch(what, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (idle_en && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_status.accepted          = accepted;
            got_status.first_head        = first_head;
            got_status.first_head_valid  = first_head_valid;
            got_status.second_head       = second_head;
            got_status.second_head_valid = second_head_valid;
            got_status.first_count       = first_count;
            got_status.second_count      = second_count;
            if (expected_status.size() == 0)
                flag_mismatch("unexpected item", 32'd0, 32'd1);
            else
            begin
                want_status = expected_status.pop_front();
                check_field("accepted", want_status.accepted, got_status.accepted);
                check_field("first_head", want_status.first_head, got_status.first_head);
                check_field("first_head_valid", want_status.first_head_valid,
                            got_status.first_head_valid);
                check_field("second_head", want_status.second_head, got_status.second_head);
                check_field("second_head_valid", want_status.second_head_valid,
                            got_status.second_head_valid);
                check_field("first_count", want_status.first_count, got_status.first_count);
                check_field("second_count", want_status.second_count,
                            got_status.second_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_QUERY;
        value        = '0;
        idle_en      = 1'b1;
        low_len      = 0;
        high_len     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_fill_to_full();
        test_random_traffic(1380);
        test_unthrottled_tail(200);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== balanced_dual_fifo_shared_store_core.f =====
+incdir+rtl/core
rtl/core/bdfs_pkg.sv
rtl/core/bdfs_ctrl.sv
rtl/core/bdfs_dpath.sv
rtl/core/balanced_dual_fifo_shared_store_core.sv
dv/balanced_dual_fifo_shared_store_core_tb.sv
